/* rtl/alor_pkg.sv */
// Shared constants for the audio looper: store geometry, rate modes and LED codes.
`default_nettype none
package alor_pkg;

  localparam int ADDR_BITS   = 18;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;

  localparam logic [1:0] RATE_NORMAL = 2'd0;
  localparam logic [1:0] RATE_INTERP = 2'd1;
  localparam logic [1:0] RATE_DECIM  = 2'd2;
  localparam logic [1:0] RATE_RESET  = RATE_DECIM;

  localparam logic [7:0] LED_OFF     = 8'h00;
  localparam logic [7:0] LED_RECORD  = 8'h01;
  localparam logic [7:0] LED_CLEAR   = 8'hFF;
  localparam logic [7:0] LED_PLAY    = 8'h03;
  localparam logic [7:0] LED_OVERDUB = 8'h09;

endpackage
`default_nettype wire

/* rtl/audio_looper_overdub_resample_top.sv */
// Audio looper top level: sequencer, single-port sample store and output register.
//
// One request per audio tick. Each request runs through accesses to the single-port
// sample store: while recording, an overdub read and write-back or an append write,
// then one playback read, two when four-times interpolation starts a new pair, none
// in its other phases. The result waits in an output register, so the next request
// is taken while an earlier result is still unread. The store is not cleared after
// reset. rate_mode is written through cfg_wr_en/cfg_wr_data; the user must do so only
// while the block is idle, as the block itself does not enforce it.
`default_nettype none
module audio_looper_overdub_resample_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,   // rate_mode
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,       // [15:0] sample_in
  input  wire logic [3:0]  s_tuser,       // [0] record_toggle, [1] clear_press,
                                          // [2] play_press, [3] overdub_enable
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,       // [15:0] sample_out, [23:16] led_pattern
  output logic [1:0]       m_tuser        // [0] recording, [1] playing
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ODRD = 3'd1;
  localparam logic [2:0] S_MIX  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_PLAY = 3'd4;
  localparam logic [2:0] S_RD2  = 3'd5;
  localparam logic [2:0] S_RDW  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]  state;
  logic [1:0]  rate_mode;
  logic [31:0] record_end;
  logic [31:0] overdub_pos;
  logic [31:0] play_pos;
  logic        record_on;
  logic        play_on;
  logic [1:0]  interp_phase;
  logic signed [15:0] held_first;
  logic signed [15:0] held_second;
  logic [7:0]  led_reg;
  logic signed [15:0] sample;
  logic signed [15:0] outv;

  // store
  logic [15:0] mem [alor_pkg::STORE_DEPTH];
  logic [alor_pkg::ADDR_BITS-1:0] mem_addr;
  logic        mem_we;
  logic [15:0] mem_wdata;
  logic signed [15:0] rdata;

  // request decode
  logic        s_accept;
  logic        rec_n;
  logic [7:0]  led_n;
  logic [31:0] rend_n;
  logic [31:0] odp_n;
  logic [31:0] ppos_n;
  logic        od_active;

  logic        play_active;
  logic [31:0] play_pos_inc;
  logic signed [16:0] diff;
  logic signed [18:0] scaled;
  logic signed [18:0] interp_val;
  logic signed [16:0] mixed;
  logic        play_end;
  logic        out_free;

  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Apply toggle, clear, play and overdub in order before any store access.
  always_comb begin
    rec_n  = record_on ^ s_tuser[0];
    led_n  = led_reg;
    rend_n = record_end;
    odp_n  = overdub_pos;
    ppos_n = play_pos;
    if (s_tuser[0]) begin
      led_n = rec_n ? alor_pkg::LED_RECORD : alor_pkg::LED_OFF;
    end
    if (s_tuser[1]) begin
      led_n  = alor_pkg::LED_CLEAR;
      rend_n = '0;
      odp_n  = '0;
      ppos_n = '0;
    end
    if (s_tuser[2]) begin
      led_n = alor_pkg::LED_PLAY;
    end
    od_active = s_tuser[3] && rec_n;
    if (od_active) begin
      led_n = alor_pkg::LED_OVERDUB;
      if (odp_n > rend_n) begin
        rend_n = odp_n;
      end
    end
  end

  assign mixed = 17'(rdata >>> 1) + 17'(sample >>> 1);

  assign play_active  = play_on && (play_pos < record_end);
  assign play_pos_inc = play_pos + 32'd1;
  assign diff         = 17'(held_second) - 17'(held_first);
  assign scaled       = 19'(diff * $signed({1'b0, interp_phase}));
  assign interp_val   = 19'(held_first) + (scaled >>> 2);
  assign play_end     = play_on && (play_pos >= record_end);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = sample;
    mem_addr  = play_pos[alor_pkg::ADDR_BITS-1:0];
    unique case (state)
      S_ODRD: mem_addr = overdub_pos[alor_pkg::ADDR_BITS-1:0];
      S_MIX: begin
        mem_addr  = overdub_pos[alor_pkg::ADDR_BITS-1:0];
        mem_we    = 1'b1;
        mem_wdata = mixed[15:0];
      end
      S_WR: begin
        mem_addr = record_end[alor_pkg::ADDR_BITS-1:0];
        mem_we   = 1'b1;
      end
      S_RD2: mem_addr = play_pos_inc[alor_pkg::ADDR_BITS-1:0];
      default: mem_addr = play_pos[alor_pkg::ADDR_BITS-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_mode <= alor_pkg::RATE_RESET;
    end else if (cfg_wr_en) begin
      rate_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      record_end   <= '0;
      overdub_pos  <= '0;
      play_pos     <= '0;
      record_on    <= 1'b0;
      play_on      <= 1'b0;
      interp_phase <= '0;
      held_first   <= '0;
      held_second  <= '0;
      led_reg      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_accept) begin
            sample      <= s_tdata;
            record_on   <= rec_n;
            led_reg     <= led_n;
            record_end  <= rend_n;
            overdub_pos <= odp_n;
            play_pos    <= ppos_n;
            play_on     <= play_on || s_tuser[2];
            if (!rec_n) begin
              state <= S_PLAY;
            end else if (s_tuser[3]) begin
              state <= S_ODRD;
            end else begin
              state <= S_WR;
            end
          end
        end
        S_ODRD: state <= S_MIX;
        S_MIX: begin
          overdub_pos <= overdub_pos + 32'd1;
          state       <= S_PLAY;
        end
        S_WR: begin
          record_end <= record_end + 32'd1;
          state      <= S_PLAY;
        end
        S_PLAY: begin
          outv <= '0;
          if (!play_active) begin
            state <= S_FIN;
          end else if (rate_mode == alor_pkg::RATE_INTERP) begin
            interp_phase <= interp_phase + 2'd1;
            if (interp_phase == 2'd0) begin
              state <= S_RD2;
            end else begin
              outv <= interp_val[15:0];
              if (interp_phase == 2'd3) begin
                play_pos <= play_pos + 32'd1;
              end
              state <= S_FIN;
            end
          end else begin
            // read issued at the old pointer this cycle
            play_pos <= play_pos + ((rate_mode == alor_pkg::RATE_DECIM) ? 32'd4 : 32'd1);
            state    <= S_RDW;
          end
        end
        S_RD2: begin
          held_first <= rdata;
          state      <= S_RDW;
        end
        S_RDW: begin
          if (rate_mode == alor_pkg::RATE_INTERP) begin
            held_second <= rdata;
            outv        <= held_first;
          end else begin
            outv <= rdata;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            m_tuser <= {play_on && !play_end, record_on};
            if (play_end) begin
              m_tdata      <= {alor_pkg::LED_OFF, 16'd0};
              led_reg      <= alor_pkg::LED_OFF;
              overdub_pos  <= record_end;
              play_pos     <= record_end;
              interp_phase <= '0;
              play_on      <= 1'b0;
            end else begin
              m_tdata <= {led_reg, play_on ? outv : 16'sd0};
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // load a finished result, or drop the one just taken
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  a_silent_when_stopped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata[15:0] == 16'd0))
    else $error("sample_out not zero while playback is off");

  a_phase_only_playing: assert property (@(posedge clk) disable iff (rst)
    (interp_phase != 2'd0) |-> play_on)
    else $error("interpolation phase left running after playback ended");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("store written outside a request");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("second request taken while one is in progress");

endmodule
`default_nettype wire
